FILE: src/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// shared constants, codes and types of the receive ring buffer
// ----------------------------------------------------------------------------
package rrb_pkg;

   // field widths
   localparam int unsigned ACTION_W    = 3;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned AMOUNT_W    = 9;
   localparam int unsigned FILL_W      = 9;
   localparam int unsigned RING_SIZE_W = 10;

   // configuration
   localparam int unsigned RING_DEPTH_DEFAULT = 512;
   localparam int unsigned RING_SIZE_RESET    = 512;
   localparam int unsigned RING_SIZE_MIN      = 2;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_APPEND  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PEEK    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CONSUME = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_COUNT   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   data_byte;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic [FILL_W-1:0] fill_level;
      logic              dropped_oldest;
   } rsp_type;

   // memory port command
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

FILE: src/rrb_chan_if.sv
// ----------------------------------------------------------------------------
// rrb_chan_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface rrb_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

FILE: src/receive_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// receive_ring_buffer_top
// byte receive ring with overwrite of the oldest byte
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake                    carries
//  req_chan   in   valid/ready                  action, data_byte, amount
//  rsp_chan   out  valid/ready                  read_byte, fill_level, dropped_oldest
//  csr_*      in   csr_write_enable, no stall   ring_size (10 bits)
//
//  append, fill level report and clear pass through ST_EMIT into the result register
//  peek and consume first wait in ST_DIV for the bit-serial remainder unit
//    (one amount bit per cycle); peek then reads the store through ST_READ
//  after reset a clearing pass zeroes the store, with no intake
//  the result register lets the next request transfer while a result waits
//
module receive_ring_buffer_top #(
   parameter int unsigned RING_DEPTH = rrb_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   rrb_chan_if.sink                           req_chan,
   rrb_chan_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [rrb_pkg::RING_SIZE_W-1:0]    csr_write_data
);
   import rrb_pkg::*;

   localparam int unsigned PTR_W     = $clog2(RING_DEPTH);
   localparam int unsigned SIZE_W    = PTR_W + 1;
   localparam int unsigned CMP_W     = (SIZE_W > RING_SIZE_W) ? SIZE_W : RING_SIZE_W;
   localparam int unsigned RESET_EFF =
      (RING_SIZE_RESET > RING_DEPTH) ? RING_DEPTH : RING_SIZE_RESET;

   // effective ring size, clamped once at the register write
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [CMP_W-1:0]    csr_ext;

   mem_cmd_type         mem_cmd;
   logic [PTR_W-1:0]    mem_addr;
   logic [BYTE_W-1:0]   mem_wdata;
   logic [BYTE_W-1:0]   mem_rdata;
   logic                mod_start;
   logic [AMOUNT_W-1:0] mod_amount;
   logic                mod_done;
   logic [PTR_W-1:0]    mod_rem;

   always_comb begin
      size_in = size_ff;
      csr_ext = CMP_W'(csr_write_data);
      if (csr_write_enable) begin
         unique if (csr_ext < CMP_W'(RING_SIZE_MIN)) begin
            size_in = SIZE_W'(RING_SIZE_MIN);
         end else if (csr_ext > CMP_W'(RING_DEPTH)) begin
            size_in = SIZE_W'(RING_DEPTH);
         end else begin
            size_in = SIZE_W'(csr_ext);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(RESET_EFF);
      end else begin
         size_ff <= size_in;
      end
   end

   // sequencer owns both channels and the pointers
   rrb_ctrl #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .ptr_clear  (csr_write_enable),
      .eff_size   (size_ff),
      .mem_cmd    (mem_cmd),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata),
      .mod_start  (mod_start),
      .mod_amount (mod_amount),
      .mod_done   (mod_done),
      .mod_rem    (mod_rem)
   );

   // peek offset and consume count reduced modulo the ring size
   rrb_mod #(
      .RING_DEPTH (RING_DEPTH)
   ) u_mod (
      .clock      (clock),
      .reset      (reset),
      .mod_start  (mod_start),
      .mod_amount (mod_amount),
      .mod_size   (size_ff),
      .mod_done   (mod_done),
      .mod_rem    (mod_rem)
   );

   // byte store
   rrb_mem #(
      .RING_DEPTH (RING_DEPTH)
   ) u_mem (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // single port: never a write and a read in the same cycle
   a_mem_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("store written and read in the same cycle");

   // the remainder unit only starts on a request transfer
   a_mod_start_on_transfer: assert property (@(posedge clock) disable iff (reset)
      mod_start |-> (req_chan.valid && req_chan.ready))
      else $error("remainder unit started without a request transfer");

   // while a peek read is in flight no new request is taken
   a_read_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.rd_en |=> !req_chan.ready)
      else $error("request taken while store read pending");

   // a finished remainder never coincides with a new start
   a_mod_done_not_start: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> !mod_start)
      else $error("remainder unit restarted while delivering");

endmodule

FILE: src/rrb_mem.sv
// ----------------------------------------------------------------------------
// rrb_mem
// single-port byte store, registered read data
// ----------------------------------------------------------------------------
module rrb_mem #(
   parameter int unsigned RING_DEPTH = rrb_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  rrb_pkg::mem_cmd_type              mem_cmd,
   input  logic [$clog2(RING_DEPTH)-1:0]     mem_addr,
   input  logic [rrb_pkg::BYTE_W-1:0]        mem_wdata,
   output logic [rrb_pkg::BYTE_W-1:0]        mem_rdata
);
   import rrb_pkg::*;

   logic [BYTE_W-1:0] store_ff [RING_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         store_ff[mem_addr] <= mem_wdata;
      end
      if (mem_cmd.rd_en) begin
         rdata_ff <= store_ff[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

FILE: src/rrb_mod.sv
// ----------------------------------------------------------------------------
// rrb_mod
// bit-serial remainder of amount by ring size, one amount bit per cycle
// ----------------------------------------------------------------------------
module rrb_mod #(
   parameter int unsigned RING_DEPTH = rrb_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                mod_start,
   input  logic [rrb_pkg::AMOUNT_W-1:0]        mod_amount,
   input  logic [$clog2(RING_DEPTH):0]         mod_size,
   output logic                                mod_done,
   output logic [$clog2(RING_DEPTH)-1:0]       mod_rem
);
   import rrb_pkg::*;

   localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
   localparam int unsigned SIZE_W = PTR_W + 1;
   localparam int unsigned CNT_W  = $clog2(AMOUNT_W);

   logic [PTR_W-1:0]    rem_ff,  rem_in;
   logic [AMOUNT_W-1:0] amt_ff,  amt_in;
   logic [CNT_W-1:0]    cnt_ff,  cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SIZE_W-1:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      amt_in  = amt_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, amt_ff[AMOUNT_W-1]};
      if (mod_start) begin
         rem_in  = '0;
         amt_in  = mod_amount;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step, trial stays below twice the size
         if (trial >= mod_size) begin
            rem_in = PTR_W'(trial - mod_size);
         end else begin
            rem_in = PTR_W'(trial);
         end
         amt_in = {amt_ff[AMOUNT_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(AMOUNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      amt_ff <= amt_in;
      cnt_ff <= cnt_in;
   end

   assign mod_done = done_ff;
   assign mod_rem  = rem_ff;

endmodule

FILE: src/rrb_ctrl.sv
// ----------------------------------------------------------------------------
// rrb_ctrl
// sequencer: pointers, store clearing pass, action decode, result register
// ----------------------------------------------------------------------------
module rrb_ctrl #(
   parameter int unsigned RING_DEPTH = rrb_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   rrb_chan_if.sink                            req_chan,
   rrb_chan_if.source                          rsp_chan,
   input  logic                                ptr_clear,
   input  logic [$clog2(RING_DEPTH):0]         eff_size,
   output rrb_pkg::mem_cmd_type                mem_cmd,
   output logic [$clog2(RING_DEPTH)-1:0]       mem_addr,
   output logic [rrb_pkg::BYTE_W-1:0]          mem_wdata,
   input  logic [rrb_pkg::BYTE_W-1:0]          mem_rdata,
   output logic                                mod_start,
   output logic [rrb_pkg::AMOUNT_W-1:0]        mod_amount,
   input  logic                                mod_done,
   input  logic [$clog2(RING_DEPTH)-1:0]       mod_rem
);
   import rrb_pkg::*;

   localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
   localparam int unsigned SIZE_W = PTR_W + 1;
   localparam int unsigned EXT_W  = (SIZE_W > FILL_W) ? SIZE_W : FILL_W;

   state_type           state_ff,   state_in;
   logic [PTR_W-1:0]    wp_ff,      wp_in;
   logic [PTR_W-1:0]    rp_ff,      rp_in;
   logic [PTR_W-1:0]    clr_ff,     clr_in;
   logic                peek_ff,    peek_in;
   logic [BYTE_W-1:0]   rbyte_ff,   rbyte_in;
   logic                drop_ff,    drop_in;
   logic                rsp_vld_ff, rsp_vld_in;
   rsp_type             rsp_ff,     rsp_in;

   logic [SIZE_W-1:0]   wp_inc;
   logic [SIZE_W-1:0]   rp_inc;
   logic [SIZE_W-1:0]   rem_sum;
   logic [PTR_W-1:0]    rem_ptr;
   logic [SIZE_W-1:0]   fill;
   logic [EXT_W-1:0]    fill_ext;
   logic                accept;

   // wrapped pointer arithmetic, all operands below the ring size
   always_comb begin
      wp_inc = SIZE_W'(wp_ff) + SIZE_W'(1);
      if (wp_inc == eff_size) begin
         wp_inc = '0;
      end
      rp_inc = SIZE_W'(rp_ff) + SIZE_W'(1);
      if (rp_inc == eff_size) begin
         rp_inc = '0;
      end
      rem_sum = SIZE_W'(rp_ff) + SIZE_W'(mod_rem);
      if (rem_sum >= eff_size) begin
         rem_sum = rem_sum - eff_size;
      end
      rem_ptr = PTR_W'(rem_sum);
      fill    = SIZE_W'(wp_ff) - SIZE_W'(rp_ff);
      if (wp_ff < rp_ff) begin
         fill = fill + eff_size;
      end
      fill_ext = EXT_W'(fill);
   end

   assign accept = req_chan.valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      clr_in     = clr_ff;
      peek_in    = peek_ff;
      rbyte_in   = rbyte_ff;
      drop_in    = drop_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      rsp_in     = rsp_ff;
      mem_cmd    = '0;
      mem_addr   = wp_ff;
      mem_wdata  = req_chan.payload.data_byte;
      mod_start  = 1'b0;
      mod_amount = req_chan.payload.amount;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_cmd.wr_en = 1'b1;
            mem_addr      = clr_ff;
            mem_wdata     = '0;
            clr_in        = clr_ff + PTR_W'(1);
            if (clr_ff == PTR_W'(RING_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rbyte_in = '0;
               drop_in  = 1'b0;
               state_in = ST_EMIT;
               unique case (req_chan.payload.action)
                  ACT_APPEND: begin
                     mem_cmd.wr_en = 1'b1;
                     wp_in         = PTR_W'(wp_inc);
                     if (wp_inc == SIZE_W'(rp_ff)) begin
                        rp_in   = PTR_W'(rp_inc);
                        drop_in = 1'b1;
                     end
                  end
                  ACT_PEEK: begin
                     mod_start = 1'b1;
                     peek_in   = 1'b1;
                     state_in  = ST_DIV;
                  end
                  ACT_CONSUME: begin
                     mod_start = 1'b1;
                     peek_in   = 1'b0;
                     state_in  = ST_DIV;
                  end
                  ACT_CLEAR: begin
                     wp_in = '0;
                     rp_in = '0;
                  end
                  default: begin
                     // fill level report and unused codes change nothing
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (mod_done) begin
               if (peek_ff) begin
                  mem_cmd.rd_en = 1'b1;
                  mem_addr      = rem_ptr;
                  state_in      = ST_READ;
               end else begin
                  rp_in    = rem_ptr;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_READ: begin
            rbyte_in = mem_rdata;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_in.read_byte      = rbyte_ff;
               rsp_in.fill_level     = fill_ext[FILL_W-1:0];
               rsp_in.dropped_oldest = drop_ff;
               rsp_vld_in            = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // ring size write restarts both pointers
      if (ptr_clear) begin
         wp_in = '0;
         rp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         wp_ff      <= '0;
         rp_ff      <= '0;
         clr_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         clr_ff     <= clr_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      peek_ff  <= peek_in;
      rbyte_ff <= rbyte_in;
      drop_ff  <= drop_in;
      rsp_ff   <= rsp_in;
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule
